### rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int unsigned HDR_BYTES = 12;
    localparam int unsigned HDR_IDX_W = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_FIRST = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = 4'd11;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [15:0] msg_type;
        logic [15:0] msg_cmd;
        logic [15:0] msg_index;
        logic [15:0] msg_total;
        logic [31:0] msg_length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [31:0] byte_offset;
        logic        last;
    } lpmd_rec_t;

endpackage

### rtl/length_prefixed_message_deframer_core.sv
// Takes one stream byte per cycle, unless stalled, with no bubbles between
// messages. Header bytes produce no beat except the last byte of a
// zero-length header; every payload byte produces one beat. Each beat is
// written into the queue from its input byte, then held in the output
// register. The input stalls only when the result queue (FIFO_DEPTH entries)
// is full, which happens only under sustained output stall.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core
// Top level: header parser front, result queue, registered output stage.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer_core
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        msg_valid,
    input  logic        msg_stall,
    output logic [15:0] msg_type,
    output logic [15:0] msg_cmd,
    output logic [15:0] msg_index,
    output logic [15:0] msg_total,
    output logic [31:0] msg_length,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [31:0] byte_offset,
    output logic        last
);
    import lpmd_pkg::*;

    logic      q_push, q_full, q_pop, q_not_empty;
    lpmd_rec_t push_rec, pop_rec, out_rec;

    lpmd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_rec      (push_rec)
    );

    lpmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    lpmd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rec       (pop_rec),
        .q_pop       (q_pop),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .out_rec     (out_rec)
    );

    assign msg_type      = out_rec.msg_type;
    assign msg_cmd       = out_rec.msg_cmd;
    assign msg_index     = out_rec.msg_index;
    assign msg_total     = out_rec.msg_total;
    assign msg_length    = out_rec.msg_length;
    assign payload_valid = out_rec.payload_valid;
    assign payload_byte  = out_rec.payload_byte;
    assign byte_offset   = out_rec.byte_offset;
    assign last          = out_rec.last;

endmodule

### rtl/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front
// Accepts stream bytes, gathers the 12-byte header and tags payload beats.
// ----------------------------------------------------------------------------
module lpmd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    output logic                data_stall,
    input  logic [7:0]          data_byte,
    input  logic                q_full,
    output logic                q_push,
    output lpmd_pkg::lpmd_rec_t q_rec
);
    import lpmd_pkg::*;

    byte_t                hdr_reg [HDR_BYTES];
    byte_t                hdr_next [HDR_BYTES];
    logic [HDR_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 in_payload_reg, in_payload_next;
    logic [31:0]          remaining_reg, remaining_next;
    logic [31:0]          length_reg, length_next;

    logic                 accept;
    logic [HDR_IDX_W-1:0] idx;
    logic [31:0]          hdr_len;

    assign data_stall = q_full;
    assign accept     = data_valid && !q_full;
    assign idx        = (cnt_reg > HDR_LAST) ? HDR_FIRST : cnt_reg;
    assign hdr_len    = {hdr_reg[8], hdr_reg[9], hdr_reg[10], data_byte};

    always_comb
    begin
        hdr_next        = hdr_reg;
        cnt_next        = cnt_reg;
        in_payload_next = in_payload_reg;
        remaining_next  = remaining_reg;
        length_next     = length_reg;
        q_push          = 1'b0;

        q_rec.msg_type      = {hdr_reg[0], hdr_reg[1]};
        q_rec.msg_cmd       = {hdr_reg[2], hdr_reg[3]};
        q_rec.msg_index     = {hdr_reg[4], hdr_reg[5]};
        q_rec.msg_total     = {hdr_reg[6], hdr_reg[7]};
        q_rec.msg_length    = length_reg;
        q_rec.payload_valid = 1'b1;
        q_rec.payload_byte  = data_byte;
        q_rec.byte_offset   = length_reg - remaining_reg;
        q_rec.last          = (remaining_reg <= 32'd1);

        if (accept)
        begin
            if (!in_payload_reg)
            begin
                hdr_next[idx] = data_byte;
                if (idx == HDR_LAST)
                begin
                    cnt_next    = HDR_FIRST;
                    length_next = hdr_len;
                    if (hdr_len == 32'd0)
                    begin
                        q_push              = 1'b1;
                        q_rec.msg_length    = 32'd0;
                        q_rec.payload_valid = 1'b0;
                        q_rec.payload_byte  = 8'd0;
                        q_rec.byte_offset   = 32'd0;
                        q_rec.last          = 1'b1;
                    end
                    else
                    begin
                        remaining_next  = hdr_len;
                        in_payload_next = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = idx + 1'b1;
                end
            end
            else
            begin
                q_push = 1'b1;
                if (remaining_reg <= 32'd1)
                begin
                    remaining_next  = 32'd0;
                    in_payload_next = 1'b0;
                end
                else
                begin
                    remaining_next = remaining_reg - 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= HDR_FIRST;
            in_payload_reg <= 1'b0;
            remaining_reg  <= 32'd0;
            length_reg     <= 32'd0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            in_payload_reg <= in_payload_next;
            remaining_reg  <= remaining_next;
            length_reg     <= length_next;
        end
    end

endmodule

### rtl/lpmd_fifo.sv
// ----------------------------------------------------------------------------
// lpmd_fifo
// Short result queue between the header/payload front and the output stage.
// ----------------------------------------------------------------------------
module lpmd_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpmd_pkg::lpmd_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output lpmd_pkg::lpmd_rec_t pop_rec
);
    import lpmd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lpmd_rec_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back
// Output register stage: drains the queue into the message channel.
// ----------------------------------------------------------------------------
module lpmd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  lpmd_pkg::lpmd_rec_t q_rec,
    output logic                q_pop,
    output logic                msg_valid,
    input  logic                msg_stall,
    output lpmd_pkg::lpmd_rec_t out_rec
);
    import lpmd_pkg::*;

    logic      valid_reg, valid_next;
    lpmd_rec_t rec_reg;

    assign q_pop      = q_not_empty && (!valid_reg || !msg_stall);
    assign valid_next = q_pop ? 1'b1 : (valid_reg && msg_stall);
    assign msg_valid  = valid_reg;
    assign out_rec    = rec_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg <= q_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

### rtl/lpmd_checker.sv
// ----------------------------------------------------------------------------
// lpmd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpmd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_stall,
    input logic [15:0] msg_type,
    input logic [15:0] msg_cmd,
    input logic [15:0] msg_index,
    input logic [15:0] msg_total,
    input logic [31:0] msg_length,
    input logic        payload_valid,
    input logic [7:0]  payload_byte,
    input logic [31:0] byte_offset,
    input logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_stall |=> msg_valid && $stable(byte_offset)
            && $stable(payload_byte) && $stable(last) && $stable(msg_length)
            && $stable(payload_valid) && $stable(msg_type) && $stable(msg_cmd)
            && $stable(msg_index) && $stable(msg_total))
        else $error("stalled beat changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !payload_valid |-> last && msg_length == 32'd0
            && byte_offset == 32'd0 && payload_byte == 8'd0)
        else $error("empty message beat malformed");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && payload_valid |-> byte_offset < msg_length)
        else $error("payload offset beyond length");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && payload_valid |-> last == (byte_offset == msg_length - 32'd1))
        else $error("last flag misplaced");

endmodule

bind length_prefixed_message_deframer_core lpmd_checker u_lpmd_checker (.*);
